>>> design/stop_and_wait_segmenting_sender_defines.svh
// Assertion macros shared by the checker of the segmenting sender.
`ifndef STOP_AND_WAIT_SEGMENTING_SENDER_DEFINES_SVH
`define STOP_AND_WAIT_SEGMENTING_SENDER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SWSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SWSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/swss_pkg.sv
// Shared constants, codes and control types of the segmenting sender.
`timescale 1ns / 1ps

package swss_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = 32;
    localparam int PKT_CAP = (MAX_PAYLOAD > STORE_DEPTH) ? STORE_DEPTH :
                             ((MAX_PAYLOAD < 1) ? 1 : MAX_PAYLOAD);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;
    localparam int SUM_W  = 13;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_RESP = 1'b1;

    localparam logic KIND_SENT = 1'b0;
    localparam logic KIND_BUSY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_byte;
        logic start_send;
        logic clear_pkt;
        logic issue;
        logic refuse;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cap_hit;
        logic rd_room;
        logic send_last;
        logic rd_busy;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/swss_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface swss_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [swss_pkg::BYTE_W-1:0] data_byte;
    logic                        message_end;
    logic                        response_nack;

    modport source (output valid, func, data_byte, message_end, response_nack,
                    input ready);
    modport sink (input valid, func, data_byte, message_end, response_nack,
                  output ready);
endinterface

interface swss_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic                              packet_type;
    logic [swss_pkg::LEN_W-1:0]        packet_length;
    logic signed [swss_pkg::SUM_W-1:0] packet_checksum;
    logic [swss_pkg::IDX_W-1:0]        byte_index;
    logic [swss_pkg::BYTE_W-1:0]       payload_byte;
    logic                              run_last;

    modport source (output valid, kind, packet_type, packet_length, packet_checksum,
                    byte_index, payload_byte, run_last,
                    input ready);
    modport sink (input valid, kind, packet_type, packet_length, packet_checksum,
                  byte_index, payload_byte, run_last,
                  output ready);
endinterface

>>> design/swss_datapath.sv
// Packet store, checksum, send sequencer and output register of the sender.
`timescale 1ns / 1ps

module swss_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  swss_pkg::dp_cmd_t           cmd,
    output swss_pkg::dp_status_t        status,
    input  logic [swss_pkg::BYTE_W-1:0] data_byte,
    input  logic                        message_end,
    swss_out_if.source                  out_ch
);

    logic [swss_pkg::BYTE_W-1:0] store_mem [swss_pkg::STORE_DEPTH];

    logic [swss_pkg::LEN_W-1:0]        fill_reg, fill_next;
    logic signed [swss_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                              held_type_reg, held_type_next;
    logic [swss_pkg::LEN_W-1:0]        held_len_reg, held_len_next;
    logic [swss_pkg::IDX_W-1:0]        idx_reg, idx_next;

    // Read stage: one memory word in flight toward the output register.
    logic                        rd_valid_reg, rd_valid_next;
    logic [swss_pkg::BYTE_W-1:0] rd_data_reg;
    logic [swss_pkg::IDX_W-1:0]  rd_idx_reg;
    logic                        rd_last_reg;

    logic                              out_valid_reg, out_valid_next;
    logic                              out_kind_reg;
    logic                              out_type_reg;
    logic [swss_pkg::LEN_W-1:0]        out_len_reg;
    logic signed [swss_pkg::SUM_W-1:0] out_sum_reg;
    logic [swss_pkg::IDX_W-1:0]        out_idx_reg;
    logic [swss_pkg::BYTE_W-1:0]       out_byte_reg;
    logic                              out_last_reg;

    logic [swss_pkg::LEN_W-1:0] fill_inc;
    logic                       out_free;
    logic                       rd_to_out;
    logic                       send_last;

    assign fill_inc  = fill_reg + swss_pkg::LEN_W'(1);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign rd_to_out = rd_valid_reg && out_free;
    assign send_last = (swss_pkg::LEN_W'(idx_reg) + swss_pkg::LEN_W'(1)) == held_len_reg;

    assign status.cap_hit   = (fill_inc >= swss_pkg::LEN_W'(swss_pkg::PKT_CAP)) || message_end;
    assign status.rd_room   = !rd_valid_reg || rd_to_out;
    assign status.send_last = send_last;
    assign status.rd_busy   = rd_valid_reg && !out_free;
    assign status.out_free  = out_free;

    always_comb
    begin
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        held_type_next = held_type_reg;
        held_len_next  = held_len_reg;
        idx_next       = idx_reg;
        if (cmd.store_byte)
        begin
            fill_next = fill_inc;
            sum_next  = sum_reg + swss_pkg::SUM_W'($signed(data_byte));
            if (status.cap_hit)
            begin
                held_type_next = message_end;
                held_len_next  = fill_inc;
            end
        end
        if (cmd.clear_pkt)
        begin
            fill_next = '0;
            sum_next  = '0;
        end
        if (cmd.start_send)
        begin
            idx_next = '0;
        end
        else if (cmd.issue)
        begin
            idx_next = idx_reg + swss_pkg::IDX_W'(1);
        end
    end

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (cmd.issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (rd_to_out)
        begin
            rd_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (rd_to_out || cmd.refuse)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            sum_reg       <= '0;
            held_type_reg <= 1'b0;
            held_len_reg  <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            held_type_reg <= held_type_next;
            held_len_reg  <= held_len_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Single-port style store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            store_mem[fill_reg[swss_pkg::IDX_W-1:0]] <= data_byte;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= store_mem[idx_reg];
            rd_idx_reg  <= idx_reg;
            rd_last_reg <= send_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_to_out)
        begin
            out_kind_reg <= swss_pkg::KIND_SENT;
            out_type_reg <= held_type_reg;
            out_len_reg  <= held_len_reg;
            out_sum_reg  <= sum_reg;
            out_idx_reg  <= rd_idx_reg;
            out_byte_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
        end
        else if (cmd.refuse)
        begin
            out_kind_reg <= swss_pkg::KIND_BUSY;
            out_type_reg <= 1'b0;
            out_len_reg  <= '0;
            out_sum_reg  <= '0;
            out_idx_reg  <= '0;
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.kind            = out_kind_reg;
    assign out_ch.packet_type     = out_type_reg;
    assign out_ch.packet_length   = out_len_reg;
    assign out_ch.packet_checksum = out_sum_reg;
    assign out_ch.byte_index      = out_idx_reg;
    assign out_ch.payload_byte    = out_byte_reg;
    assign out_ch.run_last        = out_last_reg;

endmodule

>>> design/swss_controller.sv
// Controller state machine: gathers bytes, runs sends and handles responses.
`timescale 1ns / 1ps

module swss_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    swss_in_if.sink              in_ch,
    input  swss_pkg::dp_status_t status,
    output swss_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SEND  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   ready;
    logic   accept;

    // Input is open while gathering, and while waiting if the output register has room.
    assign ready       = (state_reg == ST_IDLE) || ((state_reg == ST_WAIT) && status.out_free);
    assign in_ch.ready = ready;
    assign accept      = in_ch.valid && ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // A response with nothing outstanding is simply dropped.
                if (accept && in_ch.func == swss_pkg::FUNC_BYTE)
                begin
                    cmd.store_byte = 1'b1;
                    if (status.cap_hit)
                    begin
                        cmd.start_send = 1'b1;
                        state_next     = ST_SEND;
                    end
                end
            end
            ST_SEND:
            begin
                cmd.issue = status.rd_room;
                if (status.rd_room && status.send_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.rd_busy)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (accept)
                begin
                    if (in_ch.func == swss_pkg::FUNC_BYTE)
                    begin
                        cmd.refuse = 1'b1;
                    end
                    else if (in_ch.response_nack)
                    begin
                        cmd.start_send = 1'b1;
                        state_next     = ST_SEND;
                    end
                    else
                    begin
                        cmd.clear_pkt = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/stop_and_wait_segmenting_sender.sv
// Stop-and-wait segmenting sender: top level joining controller and datapath.
//
// in_ch carries items: a message byte (func 0, with message_end) or a peer
// response (func 1, response_nack). out_ch carries one result per packet byte
// sent, or one busy result for a byte refused while a packet is outstanding.
// Message bytes are taken one per cycle while no packet is outstanding and
// produce no result until the packet fills or the message ends.
// While a send runs, in_ch.ready is held low: the packet store has one
// registered read port, so one byte is read per cycle while the read stage has
// room, and each byte passes through the read register and the output register.
// After a send the block takes responses and bytes one per cycle while out_ch
// has room: an ACK frees it, a NACK resends the held packet, a byte gets a
// busy result in the next cycle.
// A result waits in an output register while out_ch.ready is low; the send
// pauses and input is held off only when that register cannot be emptied.
// Reset (rst_n low, asynchronous) empties the block: no packet outstanding,
// byte count and checksum zero, no result pending.
`timescale 1ns / 1ps

module stop_and_wait_segmenting_sender (
    input logic        clk,
    input logic        rst_n,
    swss_in_if.sink    in_ch,
    swss_out_if.source out_ch
);

    swss_pkg::dp_cmd_t    cmd;
    swss_pkg::dp_status_t status;

    swss_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .status (status),
        .cmd    (cmd)
    );

    swss_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_byte   (in_ch.data_byte),
        .message_end (in_ch.message_end),
        .out_ch      (out_ch)
    );

endmodule

>>> design/swss_checker.sv
// Port-level checker for the segmenting sender, bound to the top level.
`timescale 1ns / 1ps
`include "stop_and_wait_segmenting_sender_defines.svh"

module swss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              kind,
    input logic                              packet_type,
    input logic [swss_pkg::LEN_W-1:0]        packet_length,
    input logic signed [swss_pkg::SUM_W-1:0] packet_checksum,
    input logic [swss_pkg::IDX_W-1:0]        byte_index,
    input logic [swss_pkg::BYTE_W-1:0]       payload_byte,
    input logic                              run_last
);

    // A busy result carries nothing but its kind and the end of its run.
    `SWSS_ASSERT_NOW(a_busy_shape, out_valid && kind == swss_pkg::KIND_BUSY,
        !packet_type && packet_length == '0 && packet_checksum == '0 &&
        byte_index == '0 && payload_byte == '0 && run_last,
        "busy result with nonzero fields")

    // A sent byte lies inside its packet.
    `SWSS_ASSERT_NOW(a_index_in_range, out_valid && kind == swss_pkg::KIND_SENT,
        packet_length != '0 && swss_pkg::LEN_W'(byte_index) < packet_length,
        "byte index outside packet")

    // The run ends exactly on the packet's final byte.
    `SWSS_ASSERT_NOW(a_run_last_pos, out_valid && kind == swss_pkg::KIND_SENT,
        run_last == ((swss_pkg::LEN_W'(byte_index) + swss_pkg::LEN_W'(1)) == packet_length),
        "run_last misplaced")

    // A stalled result holds.
    `SWSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(kind) && $stable(byte_index) && $stable(payload_byte) &&
        $stable(packet_checksum),
        "stalled result changed")

endmodule

bind stop_and_wait_segmenting_sender swss_checker u_swss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .kind            (out_ch.kind),
    .packet_type     (out_ch.packet_type),
    .packet_length   (out_ch.packet_length),
    .packet_checksum (out_ch.packet_checksum),
    .byte_index      (out_ch.byte_index),
    .payload_byte    (out_ch.payload_byte),
    .run_last        (out_ch.run_last)
);
